[src/wrrc_pkg.sv]
// Package for the waveform rise run check block.
// Holds waveform lengths, the surface bin limit, field widths and register indexes.
// No dependencies.
package wrrc_pkg;

  localparam int unsigned APD_LENGTH    = 256;
  localparam int unsigned PMT_LENGTH    = 512;
  localparam int unsigned SURFACE_LIMIT = 20;

  localparam int unsigned BinW   = 9;
  localparam int unsigned SwW    = 9;
  localparam int unsigned ThrW   = 8;
  localparam int unsigned ValW   = 10;
  localparam int unsigned CountW = 8;
  // Window bounds: bin + width and length - 1 both fit here.
  localparam int unsigned WinW   = 11;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 9;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_HALF_WIDTH = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_RUN_LIMIT  = cfg_idx_t'(1);

  typedef enum logic {
    FUNC_SAMPLE  = 1'b0,
    FUNC_VERDICT = 1'b1
  } func_e;

  localparam logic [WinW-1:0] SurfaceW   = WinW'(SURFACE_LIMIT);
  localparam logic [WinW-1:0] ApdLastW   = WinW'(APD_LENGTH - 1);
  localparam logic [WinW-1:0] PmtLastW   = WinW'(PMT_LENGTH - 1);
  localparam logic [WinW-1:0] ApdLateW   = WinW'(APD_LENGTH - SURFACE_LIMIT);
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

endpackage

[src/waveform_rise_run_check.sv]
// Top level of the waveform rise run check block.
// Depends on wrrc_pkg for constants, widths and register indexes.
//
// Usage: neighbor waveform samples arrive on the input channel (valid/stall),
// in index order, each tagged with its channel and carrying the record's
// bottom bins. A request with func = 1 ends the record and yields one result
// on the output channel: clean = 1 when the selected bin is 20 or above and
// no run of run-limit rises unbroken by a fall was seen inside the window.
// Sample requests yield no result.
// A request is held in the input register, then the state update and the verdict
// register are written, and a verdict is presented from the verdict register.
// Throughput is one request per cycle while no verdict waits behind a held one,
// set by the run-count update loop through the run-state registers.
// When the receiver stalls, the verdict holds in its output register; sample
// requests keep flowing, and the input stalls only when a second verdict
// must wait behind the held one.
// Reset clears the pipeline valids and run state and loads a half width of 10
// and a run limit of 3. Configuration is written through cfg_we_i; the user must
// write it only while the block is idle, as the block itself does not enforce this.
module waveform_rise_run_check (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  wrrc_pkg::cfg_idx_t                 cfg_index_i,
  input  logic [wrrc_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               func_i,
  input  logic [wrrc_pkg::BinW-1:0]          first_bin_i,
  input  logic [wrrc_pkg::BinW-1:0]          second_bin_i,
  input  logic                               use_second_i,
  input  logic                               channel_i,
  input  logic [wrrc_pkg::BinW-1:0]          sample_index_i,
  input  logic [wrrc_pkg::ValW-1:0]          sample_value_i,
  input  logic                               waveform_end_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               clean_o
);
  import wrrc_pkg::*;

  // Configuration registers.
  logic [SwW-1:0]  half_width_q;
  logic [ThrW-1:0] run_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= SwW'(10);
      run_limit_q  <= ThrW'(3);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HALF_WIDTH: half_width_q <= cfg_wdata_i[SwW-1:0];
        CFG_RUN_LIMIT:  run_limit_q  <= cfg_wdata_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic              s1_valid_q;
  func_e             s1_func_q;
  logic [BinW-1:0]   s1_bin_q;
  logic              s1_pmt_q;
  logic [BinW-1:0]   s1_idx_q;
  logic [ValW-1:0]   s1_val_q;
  logic              s1_wend_q;

  logic out_valid_q;
  logic out_clean_q;
  logic out_free;
  logic s1_adv;
  logic in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && ((s1_func_q == FUNC_SAMPLE) || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q <= func_e'(func_i);
      s1_bin_q  <= use_second_i ? second_bin_i : first_bin_i;
      s1_pmt_q  <= channel_i;
      s1_idx_q  <= sample_index_i;
      s1_val_q  <= sample_value_i;
      s1_wend_q <= waveform_end_i;
    end
  end

  // Window test for the registered sample.
  logic [WinW-1:0] bin_w, sw_w, idx_w, start_w, stop_w, last_w, sum_w;
  logic            below_surface, active, in_window;

  always_comb begin
    bin_w  = WinW'(s1_bin_q);
    sw_w   = WinW'(half_width_q);
    idx_w  = WinW'(s1_idx_q);
    sum_w  = bin_w + sw_w;
    last_w = s1_pmt_q ? PmtLastW : ApdLastW;
    // bin - width below the surface limit clamps to the limit.
    start_w = (bin_w < sw_w + SurfaceW) ? SurfaceW : (bin_w - sw_w);
    stop_w  = (sum_w > last_w) ? last_w : sum_w;
    below_surface = bin_w < SurfaceW;
    active  = !below_surface && !(!s1_pmt_q && (start_w >= ApdLateW));
    in_window = active && (idx_w >= start_w) && (idx_w < stop_w);
  end

  // Run state.
  logic [ValW-1:0]   prev_q, prev_d;
  logic [CountW-1:0] count_q, count_d, count_upd;
  logic              rise_q, rise_d;

  always_comb begin
    prev_d    = prev_q;
    count_d   = count_q;
    rise_d    = rise_q;
    count_upd = count_q;
    if (s1_adv) begin
      if (s1_func_q == FUNC_VERDICT) begin
        prev_d  = '0;
        count_d = '0;
        rise_d  = 1'b0;
      end else begin
        if (in_window) begin
          if (s1_val_q > prev_q) begin
            if (count_q != CountMax) begin
              count_upd = count_q + CountW'(1);
            end
          end else if (s1_val_q < prev_q) begin
            count_upd = '0;
          end
          if (count_upd >= run_limit_q) begin
            rise_d = 1'b1;
          end
        end
        prev_d  = s1_val_q;
        count_d = s1_wend_q ? '0 : count_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      count_q <= '0;
      rise_q  <= 1'b0;
    end else begin
      prev_q  <= prev_d;
      count_q <= count_d;
      rise_q  <= rise_d;
    end
  end

  // Verdict register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && (s1_func_q == FUNC_VERDICT)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && (s1_func_q == FUNC_VERDICT)) begin
      out_clean_q <= !below_surface && !rise_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign clean_o     = out_clean_q;

  // A stall toward the sender only happens with a request waiting.
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && (s1_func_q == FUNC_VERDICT) && out_valid_q))
    else $error("input stalled without a blocked verdict");

  // Ending a record returns the run state to zero.
  a_verdict_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && (s1_func_q == FUNC_VERDICT)) |=>
      (!rise_q && (count_q == '0) && (prev_q == '0)))
    else $error("run state not cleared after verdict");

  // A new verdict appears only when an end-of-record request left stage one.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv && (s1_func_q == FUNC_VERDICT)))
    else $error("verdict without end-of-record request");

  // A surface bin never reports clean.
  a_surface_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && (s1_func_q == FUNC_VERDICT) && below_surface) |=> !out_clean_q)
    else $error("surface bin reported clean");

endmodule

[bench/tb.sv]
// Testbench for the waveform rise run check block: directed records, then random records
// under several register settings, each verdict checked against an in-bench run-count predictor.
// Depends on wrrc_pkg and waveform_rise_run_check.
module tb;
  import wrrc_pkg::*;

  localparam int SurfBin = int'(SURFACE_LIMIT);
  localparam int ApdBins = int'(APD_LENGTH);
  localparam int PmtBins = int'(PMT_LENGTH);

  typedef struct {
    func_e            func;
    logic [BinW-1:0]  first_bin;
    logic [BinW-1:0]  second_bin;
    logic             use_second;
    logic             channel;
    logic [BinW-1:0]  index;
    logic [ValW-1:0]  value;
    logic             wave_end;
  } wave_req_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  cfg_idx_t            cfg_index_i = CFG_HALF_WIDTH;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                func_i = 1'b0;
  logic [BinW-1:0]     first_bin_i = '0;
  logic [BinW-1:0]     second_bin_i = '0;
  logic                use_second_i = 1'b0;
  logic                channel_i = 1'b0;
  logic [BinW-1:0]     sample_index_i = '0;
  logic [ValW-1:0]     sample_value_i = '0;
  logic                waveform_end_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                clean_o;

  // Predictor state and its copy of the registers.
  logic [SwW-1:0]    width_reg = SwW'(10);
  logic [ThrW-1:0]   thresh_reg = ThrW'(3);
  logic [ValW-1:0]   last_value = '0;
  logic [CountW-1:0] run_count = '0;
  bit                rise_seen = 1'b0;

  bit pending_clean[$];
  int mismatches = 0;
  int sent_count = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int stall_tick = 0;
  int stall_mode = 0;

  waveform_rise_run_check u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .first_bin_i    (first_bin_i),
    .second_bin_i   (second_bin_i),
    .use_second_i   (use_second_i),
    .channel_i      (channel_i),
    .sample_index_i (sample_index_i),
    .sample_value_i (sample_value_i),
    .waveform_end_i (waveform_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .clean_o        (clean_o)
  );

  always #6 clk_i = ~clk_i;

  // Receiver stall pattern: the mode is redrawn at random whenever the tick counter runs out.
  always @(posedge clk_i) begin
    if (stall_tick == 0) begin
      stall_mode <= int'($urandom_range(0, 3));
      stall_tick <= 150;
    end else begin
      stall_tick <= stall_tick - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 2) == 0);
      2: out_stall_i <= (stall_tick[1:0] == 2'd0);
      default: out_stall_i <= (stall_tick[3:0] < 4'd5);
    endcase
  end

  always @(posedge clk_i) begin : check_verdict
    bit want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_clean.size() == 0) begin
        $display("%0t: verdict with none expected, actual clean %0d", $time, clean_o);
        mismatches++;
      end else begin
        want = pending_clean.pop_front();
        if (clean_o !== want) begin
          $display("%0t: clean mismatch, expected %0d, actual %0d", $time, want, clean_o);
          mismatches++;
        end
      end
    end
  end

  function automatic wave_req_t mk_req(input func_e f, input int fb, input int sb,
                                       input int u2, input int ch, input int idx,
                                       input int val, input int we);
    wave_req_t r;
    r.func       = f;
    r.first_bin  = BinW'(fb);
    r.second_bin = BinW'(sb);
    r.use_second = u2[0];
    r.channel    = ch[0];
    r.index      = BinW'(idx);
    r.value      = ValW'(val);
    r.wave_end   = we[0];
    return r;
  endfunction

  // Applies one accepted request to the predicted run state.
  function automatic void update_run_state(input wave_req_t r);
    int  bin;
    int  len;
    int  start_b;
    int  stop_b;
    int  idx;
    bit  active;
    bin = r.use_second ? int'(r.second_bin) : int'(r.first_bin);
    if (r.func == FUNC_VERDICT) begin
      pending_clean.push_back((bin >= SurfBin) && !rise_seen);
      last_value = '0;
      run_count  = '0;
      rise_seen  = 1'b0;
    end else begin
      len     = r.channel ? PmtBins : ApdBins;
      start_b = bin - int'(width_reg);
      stop_b  = bin + int'(width_reg);
      idx     = int'(r.index);
      active  = 1'b1;
      if (start_b < SurfBin) start_b = SurfBin;
      if (stop_b > len - 1) stop_b = len - 1;
      if (!r.channel && start_b >= ApdBins - SurfBin) active = 1'b0;
      if (bin < SurfBin) active = 1'b0;
      if (active && idx >= start_b && idx < stop_b) begin
        if (r.value > last_value) begin
          if (run_count != CountMax) run_count = run_count + 1'b1;
        end else if (r.value < last_value) begin
          run_count = '0;
        end
        if (run_count >= thresh_reg) rise_seen = 1'b1;
      end
      last_value = r.value;
      if (r.wave_end) run_count = '0;
    end
  endfunction

  task automatic send_request(input wave_req_t r);
    in_valid_i     <= 1'b1;
    func_i         <= r.func;
    first_bin_i    <= r.first_bin;
    second_bin_i   <= r.second_bin;
    use_second_i   <= r.use_second;
    channel_i      <= r.channel;
    sample_index_i <= r.index;
    sample_value_i <= r.value;
    waveform_end_i <= r.wave_end;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    update_run_state(r);
    sent_count++;
  endtask

  // Sends in bursts of random length; while gaps are on, most bursts start after a random gap.
  task automatic issue(input wave_req_t r);
    if (burst_left == 0) begin
      burst_left = int'($urandom_range(1, 24));
      if (gaps_on && $urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    send_request(r);
  endtask

  task automatic sample(input int bin, input int ch, input int idx, input int val,
                        input int we);
    issue(mk_req(FUNC_SAMPLE, bin, int'($urandom_range(0, 511)), 0, ch, idx, val, we));
  endtask

  task automatic verdict(input int bin);
    issue(mk_req(FUNC_VERDICT, bin, int'($urandom_range(0, 511)), 0,
                 int'($urandom_range(0, 1)), int'($urandom_range(0, 511)),
                 int'($urandom_range(0, 1023)), int'($urandom_range(0, 1))));
  endtask

  // Waits until every verdict has come and the pipeline has emptied.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_clean.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Each write drops the write enable and waits before returning, so back-to-back writes never collide.
  task automatic write_reg(input cfg_idx_t idx, input int data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= CfgDataW'(data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_HALF_WIDTH) width_reg = SwW'(data);
    else thresh_reg = ThrW'(data);
    @(posedge clk_i);
  endtask

  // Reset values: three rises in the window around bin 100 mark a return.
  task automatic test_rising_run();
    sample(100, 1, 95, 5, 0);
    sample(100, 1, 96, 6, 0);
    sample(100, 1, 97, 7, 0);
    sample(100, 1, 98, 8, 1);
    verdict(100);
  endtask

  task automatic test_surface_bin();
    issue(mk_req(FUNC_VERDICT, 511, 19, 1, 0, 0, 0, 0));
    issue(mk_req(FUNC_VERDICT, 20, 0, 0, 1, 511, 1023, 1));
  endtask

  // A window starting in the last 20 bins skips the avalanche channel only.
  task automatic test_late_avalanche();
    wait_idle();
    write_reg(CFG_HALF_WIDTH, 4);
    sample(240, 0, 237, 1, 0);
    sample(240, 0, 238, 2, 0);
    sample(240, 0, 239, 3, 1);
    verdict(240);
    sample(240, 1, 237, 1, 0);
    sample(240, 1, 238, 2, 0);
    sample(240, 1, 239, 3, 1);
    verdict(240);
  endtask

  // With a zero threshold even an equal sample inside the window marks a return.
  task automatic test_zero_threshold();
    wait_idle();
    write_reg(CFG_HALF_WIDTH, 511);
    write_reg(CFG_RUN_LIMIT, 0);
    sample(511, 1, 20, 0, 1);
    verdict(511);
    sample(511, 1, 19, 1023, 1);
    verdict(511);
  endtask

  task automatic test_waveform_end();
    wait_idle();
    write_reg(CFG_HALF_WIDTH, 10);
    write_reg(CFG_RUN_LIMIT, 2);
    sample(50, 1, 45, 1, 1);
    sample(50, 1, 46, 2, 0);
    verdict(50);
  endtask

  // Long ramps at the top threshold: 256 rises saturate the count, 254 fall short.
  task automatic test_count_limit();
    wait_idle();
    write_reg(CFG_HALF_WIDTH, 511);
    write_reg(CFG_RUN_LIMIT, 255);
    gaps_on = 1'b1;
    for (int k = 0; k < 256; k++) sample(300, 1, 20 + k, 2 * k + 1, int'(k == 255));
    verdict(300);
    for (int k = 0; k < 254; k++) sample(300, 1, 20 + k, 2 * k + 1, int'(k == 253));
    verdict(300);
  endtask

  // One record: mostly ordered waveforms around the bin, sometimes noise or cut short.
  task automatic random_record();
    int  bin;
    int  other;
    int  u2;
    int  nwave;
    int  lo;
    int  cnt;
    int  idx;
    int  vcur;
    int  ch;
    bit  cut;
    bit  done;
    wave_req_t r;
    case ($urandom_range(0, 9))
      0: bin = int'($urandom_range(0, 19));
      1: bin = int'($urandom_range(230, 280));
      2: bin = int'($urandom_range(480, 511));
      default: bin = int'($urandom_range(20, 511));
    endcase
    other = int'($urandom_range(0, 511));
    u2    = int'($urandom_range(0, 1));
    done  = 1'b0;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        r = mk_req(FUNC_SAMPLE, int'($urandom_range(0, 511)), int'($urandom_range(0, 511)),
                   int'($urandom_range(0, 1)), int'($urandom_range(0, 1)),
                   int'($urandom_range(0, 511)), int'($urandom_range(0, 1023)),
                   int'($urandom_range(0, 1)));
        issue(r);
      end
    end else begin
      nwave = int'($urandom_range(1, 3));
      for (int w = 0; w < nwave && !done; w++) begin
        ch   = int'($urandom_range(0, 1));
        lo   = bin - int'(width_reg) - int'($urandom_range(0, 4));
        if (lo < 0) lo = 0;
        cnt  = int'($urandom_range(2, 20));
        vcur = int'($urandom_range(0, 1023));
        cut  = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < cnt; k++) begin
          idx = lo + k;
          if (idx > 511) break;
          case ($urandom_range(0, 9))
            0, 1: vcur = vcur - int'($urandom_range(1, 30));
            2: ;
            default: vcur = vcur + int'($urandom_range(1, 30));
          endcase
          if (vcur < 0) vcur = 0;
          if (vcur > 1023) vcur = 1023;
          if (cut && k == cnt / 2) begin
            done = 1'b1;
            break;
          end
          r = mk_req(FUNC_SAMPLE, u2 ? other : bin, u2 ? bin : other, u2, ch, idx, vcur,
                     int'(k == cnt - 1));
          issue(r);
        end
      end
    end
    r = mk_req(FUNC_VERDICT, u2 ? other : bin, u2 ? bin : other, u2,
               int'($urandom_range(0, 1)), int'($urandom_range(0, 511)),
               int'($urandom_range(0, 1023)), int'($urandom_range(0, 1)));
    issue(r);
  endtask

  task automatic test_random_mix();
    int widths[9] = '{10, 0, 511, 1, 4, 511, 0, 25, 0};
    int threshs[9] = '{3, 0, 255, 1, 2, 0, 255, 3, 0};
    int first_sent;
    for (int p = 0; p < 9; p++) begin
      wait_idle();
      if (p == 8) begin
        write_reg(CFG_HALF_WIDTH, int'($urandom_range(0, 60)));
        write_reg(CFG_RUN_LIMIT, int'($urandom_range(1, 6)));
      end else begin
        write_reg(CFG_HALF_WIDTH, widths[p]);
        write_reg(CFG_RUN_LIMIT, threshs[p]);
      end
      gaps_on    = (p % 3 != 1);
      first_sent = sent_count;
      while (sent_count - first_sent < 130) begin
        random_record();
        if ($urandom_range(0, 24) == 0) wait_idle();
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_rising_run();
    test_surface_bin();
    test_late_avalanche();
    test_zero_threshold();
    test_waveform_end();
    test_count_limit();
    test_random_mix();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** waveform_rise_run_check: PASSED **");
    end else begin
      $display("** waveform_rise_run_check: FAILED **");
    end
    $finish;
  end

  initial begin
    #(12 * 2000000);
    $display("** waveform_rise_run_check: FAILED **");
    $finish;
  end

endmodule

[sim.f]
src/wrrc_pkg.sv
src/waveform_rise_run_check.sv
bench/tb.sv
